FILE: rtl/jsr_pkg.sv
// ----------------------------------------------------------------------------
// jsr_pkg
// Shared constants, register codes, control structs and the hue color
// function of the julia set pixel renderer.
// ----------------------------------------------------------------------------
package jsr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int C_FRAC         = 28;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 13;
  localparam int PITCH_W    = 14;
  localparam int LIMIT_W    = 12;
  localparam int CONST_W    = 32;
  localparam int ADDR_W     = 26;
  localparam int COLOR_W    = 24;
  localparam int HUE_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LINE_PITCH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG      = CFG_IDX_W'(5);

  localparam logic [DIM_W-1:0]          RST_SCREEN_WIDTH    = 13'd1024;
  localparam logic [DIM_W-1:0]          RST_SCREEN_HEIGHT   = 13'd768;
  localparam logic [PITCH_W-1:0]        RST_SCAN_LINE_PITCH = 14'd1024;
  localparam logic [LIMIT_W-1:0]        RST_ITERATION_LIMIT = 12'd300;
  localparam logic signed [CONST_W-1:0] RST_CONST_REAL      = -32'sd187904819;
  localparam logic signed [CONST_W-1:0] RST_CONST_IMAG      = 32'sd72518812;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DIV_RE,
    CS_DIV_IM,
    CS_LAUNCH,
    CS_SQR_R,
    CS_SQR_I,
    CS_PROD,
    CS_CHECK,
    CS_DONE
  } core_state_t;

  typedef struct packed {
    logic start;
    logic dbl;
  } mul_ctl_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

  function automatic logic [COLOR_W-1:0] hue_color(input logic [HUE_W-1:0] hue);
    logic [10:0] six;
    logic [2:0]  sector;
    logic [7:0]  r;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    six    = 11'(hue) * 11'd6;
    sector = 3'd0;
    if (six >= 11'd255)  sector = 3'd1;
    if (six >= 11'd510)  sector = 3'd2;
    if (six >= 11'd765)  sector = 3'd3;
    if (six >= 11'd1020) sector = 3'd4;
    if (six >= 11'd1275) sector = 3'd5;
    if (six >= 11'd1530) sector = 3'd6;
    r = 8'(six - 11'(sector) * 11'd255);
    case (sector)
      3'd0: begin
        red = 8'd255;     grn = r;          blu = 8'd0;
      end
      3'd1: begin
        red = 8'd255 - r; grn = 8'd255;     blu = 8'd0;
      end
      3'd2: begin
        red = 8'd0;       grn = 8'd255;     blu = r;
      end
      3'd3: begin
        red = 8'd0;       grn = 8'd255 - r; blu = 8'd255;
      end
      3'd4: begin
        red = r;          grn = 8'd0;       blu = 8'd255;
      end
      default: begin
        red = 8'd255;     grn = 8'd0;       blu = 8'd255 - r;
      end
    endcase
    return {red, grn, blu};
  endfunction

endpackage

FILE: rtl/jsr_mul.sv
// ----------------------------------------------------------------------------
// jsr_mul
// Shared fixed point multiplier: four half-width partial products, one per
// cycle, then a scaling shift with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module jsr_mul
  import jsr_pkg::*;
#(
  parameter int W = FRAC_BITS_DEF + 8,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mul_ctl_t            ctl,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic                done,
  output logic signed [W-1:0] res
);

  localparam int H    = (W + 1) / 2;
  localparam int ACCW = 2 * W;
  localparam logic [2:0] LAST_PP = 3'd3;
  localparam logic [2:0] FIN_CYC = 3'd5;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic                busy_r;
  logic [2:0]          cyc_r;
  logic                pp_vld_r;
  logic                done_r;
  logic                neg_r;
  logic                dbl_r;
  logic [W-1:0]        am_r;
  logic [W-1:0]        bm_r;
  logic [2*H-1:0]      pp_r;
  logic [1:0]          pp_k_r;
  logic [ACCW-1:0]     acc_r;
  logic signed [W-1:0] res_r;

  logic [H-1:0]        ah;
  logic [H-1:0]        bh;
  logic [ACCW-1:0]     pp_sh;
  logic [ACCW-1:0]     q;
  logic                big;
  logic signed [W-1:0] sat_q;

  always_comb begin
    ah = cyc_r[0] ? H'(am_r[W-1:H]) : am_r[H-1:0];
    bh = cyc_r[1] ? H'(bm_r[W-1:H]) : bm_r[H-1:0];
    case (pp_k_r)
      2'd0:    pp_sh = ACCW'(pp_r);
      2'd1:    pp_sh = ACCW'(pp_r) << H;
      default: pp_sh = ACCW'(pp_r) << (2 * H);
    endcase
    q   = dbl_r ? (acc_r >> (F - 1)) : (acc_r >> F);
    big = |q[ACCW-1:W-1];
    if (neg_r) begin
      sat_q = big ? VMIN : -q[W-1:0];
    end else begin
      sat_q = big ? VMAX : q[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cyc_r    <= 3'd0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r   <= busy_r && !ctl.start && (cyc_r == FIN_CYC);
      pp_vld_r <= busy_r && (cyc_r <= LAST_PP);
      if (ctl.start) begin
        busy_r <= 1'b1;
        cyc_r  <= 3'd0;
      end else if (busy_r) begin
        cyc_r <= cyc_r + 3'd1;
        if (cyc_r == FIN_CYC) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg_r <= a[W-1] ^ b[W-1];
      dbl_r <= ctl.dbl;
      am_r  <= W'(a[W-1] ? -a : a);
      bm_r  <= W'(b[W-1] ? -b : b);
      acc_r <= '0;
    end else begin
      if (busy_r && (cyc_r <= LAST_PP)) begin
        pp_r   <= ah * bh;
        pp_k_r <= {1'b0, cyc_r[0]} + {1'b0, cyc_r[1]};
      end
      if (pp_vld_r) begin
        acc_r <= acc_r + pp_sh;
      end
      if (busy_r && (cyc_r == FIN_CYC)) begin
        res_r <= sat_q;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("multiplier started while busy");
`endif

endmodule

FILE: rtl/jsr_div.sv
// ----------------------------------------------------------------------------
// jsr_div
// Radix-2 restoring divider for the start coordinates: one quotient bit per
// cycle, truncation toward zero, then saturation to the z range.
// ----------------------------------------------------------------------------
module jsr_div
  import jsr_pkg::*;
#(
  parameter int W    = FRAC_BITS_DEF + 8,
  parameter int F    = FRAC_BITS_DEF,
  parameter int NUMW = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  div_ctl_t            ctl,
  input  logic [NUMW-1:0]     mag,
  input  logic [DIM_W-1:0]    den,
  output logic                done,
  output logic signed [W-1:0] res
);

  localparam int NB   = NUMW + F;
  localparam int CNTW = $clog2(NB + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [CNTW-1:0]     cnt_r;
  logic                fin_r;
  logic                done_r;
  logic [NB-1:0]       dvd_r;
  logic [DIM_W-1:0]    rem_r;
  logic [DIM_W-1:0]    den_r;
  logic                neg_r;
  logic signed [W-1:0] res_r;

  logic [DIM_W:0]      trial;
  logic                ge;
  logic [DIM_W-1:0]    rem_nxt;
  logic                big;
  logic signed [W-1:0] sat_q;

  always_comb begin
    trial   = {rem_r, dvd_r[NB-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIM_W'(trial - {1'b0, den_r}) : trial[DIM_W-1:0];
    big     = |dvd_r[NB-1:W-1];
    if (neg_r) begin
      sat_q = big ? VMIN : -dvd_r[W-1:0];
    end else begin
      sat_q = big ? VMAX : dvd_r[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !ctl.start && (cnt_r == '0) && fin_r;
      if (ctl.start) begin
        cnt_r <= CNTW'(NB);
        fin_r <= 1'b0;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        fin_r <= (cnt_r == CNTW'(1));
      end else if (fin_r) begin
        fin_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= {mag, {F{1'b0}}};
      rem_r <= '0;
      den_r <= (den == '0) ? DIM_W'(1) : den;
      neg_r <= ctl.neg;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[NB-2:0], ge};
      rem_r <= rem_nxt;
    end else if (fin_r) begin
      res_r <= sat_q;
    end
  end

  assign done = done_r;
  assign res  = res_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> (cnt_r == '0 && !fin_r))
    else $error("divider started while busy");
`endif

endmodule

FILE: rtl/jsr_core.sv
// ----------------------------------------------------------------------------
// jsr_core
// Iteration sequencer: maps the pixel to z0 through the divider, then runs
// z = z^2 + c on the shared multiplier until escape or the iteration limit.
// ----------------------------------------------------------------------------
module jsr_core
  import jsr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [COORD_BITS-1:0]     pixel_x,
  input  logic [COORD_BITS-1:0]     pixel_y,
  input  logic [DIM_W-1:0]          screen_width,
  input  logic [DIM_W-1:0]          screen_height,
  input  logic [LIMIT_W-1:0]        iteration_limit,
  input  logic signed [CONST_W-1:0] const_real,
  input  logic signed [CONST_W-1:0] const_imag,
  input  logic                      ack,
  output logic                      done,
  output logic                      escaped,
  output logic [LIMIT_W-1:0]        escape_count
);

  localparam int W    = FRAC_BITS + 8;
  localparam int NUMW = ((COORD_BITS > DIM_W - 1) ? COORD_BITS : DIM_W - 1) + 2;
  localparam int CSHL = (FRAC_BITS >= C_FRAC) ? FRAC_BITS - C_FRAC : 0;
  localparam int CSHR = (FRAC_BITS >= C_FRAC) ? 0 : C_FRAC - FRAC_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W+1:0] SMAX = (W+2)'(VMAX);
  localparam logic signed [W+1:0] SMIN = (W+2)'(VMIN);
  localparam logic signed [W:0]   FOUR = {{(W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

  core_state_t          state_r;
  core_state_t          state_nxt;
  logic                 first_r;
  logic signed [W-1:0]  zr_r;
  logic signed [W-1:0]  zi_r;
  logic signed [W-1:0]  sr_r;
  logic signed [W-1:0]  si_r;
  logic signed [W-1:0]  pr_r;
  logic [LIMIT_W-1:0]   cnt_r;
  logic                 esc_r;
  logic [NUMW-1:0]      im_mag_r;
  logic                 im_neg_r;

  mul_ctl_t             mul_ctl;
  logic signed [W-1:0]  mul_a;
  logic signed [W-1:0]  mul_b;
  logic                 mul_done;
  logic signed [W-1:0]  mul_res;
  div_ctl_t             div_ctl;
  logic [NUMW-1:0]      div_mag;
  logic [DIM_W-1:0]     div_den;
  logic                 div_done;
  logic signed [W-1:0]  div_res;

  logic signed [NUMW:0] dre;
  logic signed [NUMW:0] dim;
  logic signed [NUMW:0] num_re;
  logic signed [NUMW:0] num_im;
  logic                 re_neg;
  logic [NUMW-1:0]      re_mag;
  logic [NUMW-1:0]      im_mag;
  logic signed [63:0]   cr64;
  logic signed [63:0]   ci64;
  logic signed [W-1:0]  cr;
  logic signed [W-1:0]  ci;
  logic signed [W+1:0]  nr_sum;
  logic signed [W+1:0]  ni_sum;
  logic signed [W-1:0]  nr;
  logic signed [W-1:0]  ni;
  logic signed [W:0]    mag2;
  logic                 esc_hit;
  logic [LIMIT_W-1:0]   cnt_inc;
  logic                 chk_escape;
  logic                 chk_limit;

  // start coordinate numerators and aligned constant
  always_comb begin
    dre    = signed'((NUMW+1)'(pixel_x)) - signed'((NUMW+1)'(screen_width[DIM_W-1:1]));
    dim    = signed'((NUMW+1)'(pixel_y)) - signed'((NUMW+1)'(screen_height[DIM_W-1:1]));
    num_re = dre + (dre <<< 1);
    num_im = dim <<< 1;
    re_neg = num_re[NUMW];
    re_mag = NUMW'(re_neg ? -num_re : num_re);
    im_mag = NUMW'(num_im[NUMW] ? -num_im : num_im);
    cr64   = (64'(const_real) <<< CSHL) >>> CSHR;
    ci64   = (64'(const_imag) <<< CSHL) >>> CSHR;
    cr     = cr64[W-1:0];
    ci     = ci64[W-1:0];
  end

  // next z and escape test
  always_comb begin
    nr_sum = (W+2)'(sr_r) - (W+2)'(si_r) + (W+2)'(cr);
    ni_sum = (W+2)'(pr_r) + (W+2)'(ci);
    if (nr_sum > SMAX) begin
      nr = VMAX;
    end else if (nr_sum < SMIN) begin
      nr = VMIN;
    end else begin
      nr = nr_sum[W-1:0];
    end
    if (ni_sum > SMAX) begin
      ni = VMAX;
    end else if (ni_sum < SMIN) begin
      ni = VMIN;
    end else begin
      ni = ni_sum[W-1:0];
    end
    mag2    = (W+1)'(sr_r) + (W+1)'(si_r);
    esc_hit = mag2 > FOUR;
    cnt_inc = first_r ? cnt_r : cnt_r + LIMIT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mul_ctl     = '0;
    mul_a       = zr_r;
    mul_b       = zr_r;
    div_ctl     = '0;
    div_mag     = re_mag;
    div_den     = screen_width;
    chk_escape  = 1'b0;
    chk_limit   = 1'b0;
    case (state_r)
      CS_IDLE: begin
        div_ctl.neg = re_neg;
        if (start) begin
          div_ctl.start = 1'b1;
          state_nxt     = CS_DIV_RE;
        end
      end
      CS_DIV_RE: begin
        div_mag     = im_mag_r;
        div_den     = screen_height;
        div_ctl.neg = im_neg_r;
        if (div_done) begin
          div_ctl.start = 1'b1;
          state_nxt     = CS_DIV_IM;
        end
      end
      CS_DIV_IM: begin
        if (div_done) state_nxt = CS_LAUNCH;
      end
      CS_LAUNCH: begin
        mul_ctl.start = 1'b1;
        state_nxt     = CS_SQR_R;
      end
      CS_SQR_R: begin
        mul_a = zi_r;
        mul_b = zi_r;
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = CS_SQR_I;
        end
      end
      CS_SQR_I: begin
        mul_a       = zr_r;
        mul_b       = zi_r;
        mul_ctl.dbl = 1'b1;
        if (mul_done) begin
          mul_ctl.start = 1'b1;
          state_nxt     = CS_PROD;
        end
      end
      CS_PROD: begin
        if (mul_done) state_nxt = CS_CHECK;
      end
      CS_CHECK: begin
        if (!first_r && esc_hit) begin
          chk_escape = 1'b1;
          state_nxt  = CS_DONE;
        end else if (cnt_inc >= iteration_limit) begin
          chk_limit = 1'b1;
          state_nxt = CS_DONE;
        end else begin
          state_nxt = CS_LAUNCH;
        end
      end
      CS_DONE: begin
        if (ack) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else if (state_r == CS_DIV_IM && div_done) begin
      first_r <= 1'b1;
    end else if (state_r == CS_CHECK && state_nxt == CS_LAUNCH) begin
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CS_IDLE: begin
        if (start) begin
          im_mag_r <= im_mag;
          im_neg_r <= num_im[NUMW];
        end
      end
      CS_DIV_RE: begin
        if (div_done) zr_r <= div_res;
      end
      CS_DIV_IM: begin
        if (div_done) begin
          zi_r  <= div_res;
          cnt_r <= '0;
        end
      end
      CS_SQR_R: begin
        if (mul_done) sr_r <= mul_res;
      end
      CS_SQR_I: begin
        if (mul_done) si_r <= mul_res;
      end
      CS_PROD: begin
        if (mul_done) pr_r <= mul_res;
      end
      CS_CHECK: begin
        esc_r <= chk_escape;
        if (!chk_escape) cnt_r <= cnt_inc;
        if (!chk_escape && !chk_limit) begin
          zr_r <= nr;
          zi_r <= ni;
        end
      end
      default: begin
      end
    endcase
  end

  jsr_mul #(
    .W (W),
    .F (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  jsr_div #(
    .W    (W),
    .F    (FRAC_BITS),
    .NUMW (NUMW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .mag   (div_mag),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  assign done         = (state_r == CS_DONE);
  assign escaped      = esc_r;
  assign escape_count = cnt_r;

`ifndef ASSERT_OFF
  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> (cnt_r == '0))
    else $error("count moved before first iteration");

  a_mul_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == CS_SQR_R || state_r == CS_SQR_I || state_r == CS_PROD))
    else $error("multiplier result with no product pending");
`endif

endmodule

FILE: rtl/julia_set_pixel_renderer_unit.sv
// ----------------------------------------------------------------------------
// julia_set_pixel_renderer_unit
// Julia set pixel renderer: escape-time iteration with hue wheel coloring.
// ----------------------------------------------------------------------------
// operation: two start divisions (NUMW = max(COORD_BITS,12)+2 numerator bits),
//   then escape_count+2 passes of the shared multiplier (limit+1 if inside)
// throughput: one transaction at a time, the next is taken once the result
//   has moved to the output register
// reset: synchronous active low, registers return to their default values
module julia_set_pixel_renderer_unit
  import jsr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_write_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic [COLOR_W-1:0]    out_pixel_color,
  output logic [LIMIT_W-1:0]    out_escape_count
);

  localparam int PW = (COORD_BITS + PITCH_W + 1 > ADDR_W) ? COORD_BITS + PITCH_W + 1 : ADDR_W;

  logic [DIM_W-1:0]          screen_width_r;
  logic [DIM_W-1:0]          screen_height_r;
  logic [PITCH_W-1:0]        scan_line_pitch_r;
  logic [LIMIT_W-1:0]        iteration_limit_r;
  logic signed [CONST_W-1:0] const_real_r;
  logic signed [CONST_W-1:0] const_imag_r;

  logic                      busy_r;
  logic [ADDR_W-1:0]         addr_r;
  logic                      out_valid_r;
  logic [ADDR_W-1:0]         out_addr_r;
  logic [COLOR_W-1:0]        out_color_r;
  logic [LIMIT_W-1:0]        out_count_r;

  logic                      in_fire;
  logic                      out_load;
  logic [PW-1:0]             addr_full;
  logic                      core_done;
  logic                      core_escaped;
  logic [LIMIT_W-1:0]        core_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r    <= RST_SCREEN_WIDTH;
      screen_height_r   <= RST_SCREEN_HEIGHT;
      scan_line_pitch_r <= RST_SCAN_LINE_PITCH;
      iteration_limit_r <= RST_ITERATION_LIMIT;
      const_real_r      <= RST_CONST_REAL;
      const_imag_r      <= RST_CONST_IMAG;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:    screen_width_r    <= cfg_write_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT:   screen_height_r   <= cfg_write_data[DIM_W-1:0];
        REG_SCAN_LINE_PITCH: scan_line_pitch_r <= cfg_write_data[PITCH_W-1:0];
        REG_ITERATION_LIMIT: iteration_limit_r <= cfg_write_data[LIMIT_W-1:0];
        REG_CONST_REAL:      const_real_r      <= signed'(cfg_write_data[CONST_W-1:0]);
        REG_CONST_IMAG:      const_imag_r      <= signed'(cfg_write_data[CONST_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && !busy_r;
  assign out_load  = core_done && (!out_valid_r || out_ready);
  assign addr_full = PW'(in_pixel_y) * PW'(scan_line_pitch_r) + PW'(in_pixel_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r <= addr_full[ADDR_W-1:0];
    end
    if (out_load) begin
      out_addr_r  <= addr_r;
      out_color_r <= core_escaped ? hue_color(core_count[HUE_W-1:0]) : '0;
      out_count_r <= core_count;
    end
  end

  jsr_core #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (in_fire),
    .pixel_x         (in_pixel_x),
    .pixel_y         (in_pixel_y),
    .screen_width    (screen_width_r),
    .screen_height   (screen_height_r),
    .iteration_limit (iteration_limit_r),
    .const_real      (const_real_r),
    .const_imag      (const_imag_r),
    .ack             (out_load),
    .done            (core_done),
    .escaped         (core_escaped),
    .escape_count    (core_count)
  );

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_escape_count  = out_count_r;

`ifndef ASSERT_OFF
  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> busy_r)
    else $error("core result with no transaction in flight");
`endif

endmodule

FILE: tb/julia_render_check.sv
// ----------------------------------------------------------------------------
// julia_render_check
// Watches the register port and both pixel channels of the julia set
// renderer, computes the address, color and escape count of every accepted
// pixel in Q7.28 fixed point and compares them with the results in order.
// ----------------------------------------------------------------------------
module julia_render_check
  import jsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_write_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [COORD_BITS_DEF-1:0] in_pixel_x,
  input  logic [COORD_BITS_DEF-1:0] in_pixel_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [ADDR_W-1:0]         out_pixel_address,
  input  logic [COLOR_W-1:0]        out_pixel_color,
  input  logic [LIMIT_W-1:0]        out_escape_count,
  output int                        fail_count,
  output int                        backlog
);

  localparam int     FB    = FRAC_BITS_DEF;
  localparam int     PW    = 2 * (FB + 8);
  localparam longint Q_MAX = (longint'(1) <<< (FB + 7)) - 1;
  localparam longint Q_MIN = -Q_MAX - 1;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic [LIMIT_W-1:0] count;
  } pixel_t;

  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CONST_W-1:0] c_re_q;
  logic [CONST_W-1:0] c_im_q;
  pixel_t             pending_pixels[$];
  pixel_t             want;

  function automatic longint fx_sat(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // product shifted right by s, truncated toward zero, saturated
  function automatic longint fx_mul(input longint a, input longint b, input int s);
    logic [PW-1:0] ma;
    logic [PW-1:0] mb;
    logic [PW-1:0] prod;
    bit            neg;
    longint        mag;
    neg  = (a < 0) != (b < 0);
    ma   = PW'(a < 0 ? -a : a);
    mb   = PW'(b < 0 ? -b : b);
    prod = (ma * mb) >> s;
    if (prod > PW'(Q_MAX + 1)) prod = PW'(Q_MAX + 1);
    mag = longint'(prod);
    return fx_sat(neg ? -mag : mag);
  endfunction

  // scale*(p - floor(n/2)) / n in fixed point, divisor of zero taken as one
  function automatic longint fx_start(input int unsigned p, input int unsigned n,
                                      input longint scale);
    longint d;
    longint num;
    longint q;
    bit     neg;
    d = longint'(n);
    if (n == 0) d = 1;
    num = scale * (longint'(p) - longint'(n / 2));
    neg = num < 0;
    if (neg) num = -num;
    q = (num <<< FB) / d;
    return fx_sat(neg ? -q : q);
  endfunction

  function automatic longint fx_const(input logic [CONST_W-1:0] raw);
    longint v;
    v = longint'(signed'(raw));
    if (FB >= C_FRAC) return v <<< (FB - C_FRAC);
    return v >>> (C_FRAC - FB);
  endfunction

  function automatic logic [COLOR_W-1:0] wheel_rgb(input int unsigned hue);
    int unsigned six;
    int unsigned sector;
    logic [7:0]  r;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    six    = 6 * hue;
    sector = six / 255;
    r      = 8'(six % 255);
    case (sector)
      0: begin
        red = 8'd255;     grn = r;          blu = 8'd0;
      end
      1: begin
        red = 8'd255 - r; grn = 8'd255;     blu = 8'd0;
      end
      2: begin
        red = 8'd0;       grn = 8'd255;     blu = r;
      end
      3: begin
        red = 8'd0;       grn = 8'd255 - r; blu = 8'd255;
      end
      4: begin
        red = r;          grn = 8'd0;       blu = 8'd255;
      end
      default: begin
        red = 8'd255;     grn = 8'd0;       blu = 8'd255 - r;
      end
    endcase
    return {red, grn, blu};
  endfunction

  function automatic pixel_t render_pixel(input logic [COORD_BITS_DEF-1:0] px,
                                          input logic [COORD_BITS_DEF-1:0] py);
    pixel_t      res;
    longint      zr;
    longint      zi;
    longint      nr;
    longint      ni;
    longint      cr;
    longint      ci;
    longint      four;
    int unsigned n;
    zr   = fx_start(px, width_q, 3);
    zi   = fx_start(py, height_q, 2);
    cr   = fx_const(c_re_q);
    ci   = fx_const(c_im_q);
    four = longint'(4) <<< FB;
    n    = 0;
    while (n < limit_q) begin
      nr = fx_sat(fx_mul(zr, zr, FB) - fx_mul(zi, zi, FB) + cr);
      ni = fx_sat(fx_mul(zr, zi, FB - 1) + ci);
      zr = nr;
      zi = ni;
      if (fx_mul(zr, zr, FB) + fx_mul(zi, zi, FB) > four) break;
      n++;
    end
    res.count = LIMIT_W'(n);
    res.color = (n < limit_q) ? wheel_rgb(n % 256) : '0;
    res.addr  = ADDR_W'(longint'(py) * longint'(pitch_q) + longint'(px));
    return res;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q    = RST_SCREEN_WIDTH;
      height_q   = RST_SCREEN_HEIGHT;
      pitch_q    = RST_SCAN_LINE_PITCH;
      limit_q    = RST_ITERATION_LIMIT;
      c_re_q     = RST_CONST_REAL;
      c_im_q     = RST_CONST_IMAG;
      fail_count = 0;
      pending_pixels.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:    width_q  = cfg_write_data[DIM_W-1:0];
          REG_SCREEN_HEIGHT:   height_q = cfg_write_data[DIM_W-1:0];
          REG_SCAN_LINE_PITCH: pitch_q  = cfg_write_data[PITCH_W-1:0];
          REG_ITERATION_LIMIT: limit_q  = cfg_write_data[LIMIT_W-1:0];
          REG_CONST_REAL:      c_re_q   = cfg_write_data[CONST_W-1:0];
          REG_CONST_IMAG:      c_im_q   = cfg_write_data[CONST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_pixels.push_back(render_pixel(in_pixel_x, in_pixel_y));
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $error("result transaction with no pixel pending");
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_address", want.addr, out_pixel_address);
          check_field("pixel_color", want.color, out_pixel_color);
          check_field("escape_count", want.count, out_escape_count);
        end
      end
    end
    backlog <= pending_pixels.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the julia set pixel renderer with directed corner pixels and random
// register settings and pixels under random idling on both channels, and
// reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module tb
  import jsr_pkg::*;
();

  localparam int ITEM_TARGET = 1350;
  localparam int STALL_LIMIT = 400000;
  localparam int TAIL_CYCLES = 200;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = CFG_IDX_W'(7);

  logic                      clk;
  logic                      rst_n          = 1'b0;
  logic                      cfg_write_en   = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index      = '0;
  logic [CFG_DATA_W-1:0]     cfg_write_data = '0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic [COORD_BITS_DEF-1:0] in_pixel_x     = '0;
  logic [COORD_BITS_DEF-1:0] in_pixel_y     = '0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic [ADDR_W-1:0]         out_pixel_address;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic [LIMIT_W-1:0]        out_escape_count;

  int fail_count;
  int backlog;
  int pixels_sent   = 0;
  int settings_done = 0;
  int quiet_cycles  = 0;
  bit steady        = 1'b0;

  julia_set_pixel_renderer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_escape_count (out_escape_count)
  );

  julia_render_check u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_address(out_pixel_address),
    .out_pixel_color  (out_pixel_color),
    .out_escape_count (out_escape_count),
    .fail_count       (fail_count),
    .backlog          (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: random stall before each transaction
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int bits, input bit junk);
    logic [CFG_DATA_W-1:0] hi;
    hi = junk ? ($urandom() << bits) : '0;
    return hi | v;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:             return DIM_W'($urandom_range(0, 3));
      1, 2, 3, 4, 5: return DIM_W'($urandom_range(16, 1024));
      6, 7, 8:       return DIM_W'($urandom_range(1, 4096));
      default:       return DIM_W'($urandom_range(4097, 8191));
    endcase
  endfunction

  function automatic logic [COORD_BITS_DEF-1:0] pick_coord(input int unsigned span);
    int unsigned top_c;
    if (span == 0 || $urandom_range(0, 4) == 0) begin
      return COORD_BITS_DEF'($urandom_range(0, 4095));
    end
    top_c = (span > 4096) ? 4096 : span;
    return COORD_BITS_DEF'($urandom_range(0, top_c - 1));
  endfunction

  function automatic logic [CONST_W-1:0] pick_const();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write_en   <= 1'b1;
    cfg_index      <= idx;
    cfg_write_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [PITCH_W-1:0] pitch,
                               input logic [LIMIT_W-1:0] lim,
                               input logic [CONST_W-1:0] cr, input logic [CONST_W-1:0] ci,
                               input bit junk);
    write_reg(REG_SCREEN_WIDTH, with_junk(CFG_DATA_W'(w), DIM_W, junk));
    write_reg(IDX_SPARE_LO, $urandom());
    write_reg(REG_SCREEN_HEIGHT, with_junk(CFG_DATA_W'(h), DIM_W, junk));
    write_reg(REG_SCAN_LINE_PITCH, with_junk(CFG_DATA_W'(pitch), PITCH_W, junk));
    write_reg(REG_ITERATION_LIMIT, with_junk(CFG_DATA_W'(lim), LIMIT_W, junk));
    write_reg(IDX_SPARE_HI, $urandom());
    write_reg(REG_CONST_REAL, with_junk(cr, CONST_W, junk));
    write_reg(REG_CONST_IMAG, with_junk(ci, CONST_W, junk));
    cfg_write_en <= 1'b0;
    settings_done++;
  endtask

  task automatic send_pixel(input logic [COORD_BITS_DEF-1:0] x,
                            input logic [COORD_BITS_DEF-1:0] y);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // block is idle once every pending pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase();
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [PITCH_W-1:0] pitch;
    logic [LIMIT_W-1:0] lim;
    bit                 deep;
    int                 count;
    w     = pick_dim();
    h     = pick_dim();
    pitch = ($urandom_range(0, 3) == 0) ? PITCH_W'(w) : PITCH_W'($urandom_range(0, 16383));
    deep  = $urandom_range(0, 4) == 0;
    lim   = LIMIT_W'(deep ? $urandom_range(25, 300) : $urandom_range(0, 24));
    apply_setting(w, h, pitch, lim, pick_const(), pick_const(), 1'($urandom_range(0, 1)));
    steady = $urandom_range(0, 4) == 0;
    count  = deep ? $urandom_range(6, 16) : $urandom_range(20, 60);
    repeat (count) send_pixel(pick_coord(w), pick_coord(h));
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd512, 12'd384);
    send_pixel(12'd1023, 12'd767);
    send_pixel(12'd300, 12'd500);
    send_pixel(12'd700, 12'd200);
    drain();

    // unit frame, extreme constant, start values saturate off frame
    apply_setting(13'd1, 13'd1, 14'd1, 12'd1, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // zero sizes and zero iteration limit
    apply_setting(13'd0, 13'd0, 14'd16383, 12'd0, 32'h0, 32'h0, 1'b1);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    drain();

    // widest frame, largest limit, one point that never escapes
    apply_setting(13'd8191, 13'd8191, 14'd8192, 12'd4095, 32'h0, 32'h0, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    drain();

    apply_setting(13'd4096, 13'd4096, 14'd8191, 12'd255, RST_CONST_REAL, RST_CONST_IMAG, 1'b1);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd1000, 12'd3000);
    drain();

    while (pixels_sent < ITEM_TARGET) random_phase();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pixels over %0d register settings plus the reset values",
             pixels_sent, settings_done);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/jsr_pkg.sv
rtl/jsr_mul.sv
rtl/jsr_div.sv
rtl/jsr_core.sv
rtl/julia_set_pixel_renderer_unit.sv
tb/julia_render_check.sv
tb/tb.sv
